/* hw/rtl/gcrf_pkg.sv */
// shared types and constants for the grid chain reaction flood block
// no dependencies
`default_nettype none

package gcrf_pkg;

    localparam int CFG_W = 7;

    // build limits of the grid and the bomb store
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_BOMBS  = 256;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_REACH       = 2'd2
    } reg_idx_t;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    // probe direction, one per scan arm
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

endpackage

`default_nettype wire

/* hw/rtl/gcrf_cell_map.sv */
// grid cell map: one entry per cell holding bomb index plus one, zero when empty
// uses gcrf_pkg; an epoch tag per cell makes a case clear a single counter step
`default_nettype none

module gcrf_cell_map
    import gcrf_pkg::*;
#(
    parameter int ADDR_W  = 12,
    parameter int DATA_W  = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              clear,
    output logic      [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;
    localparam int EPOCH_W = 8;

    logic [DATA_W+EPOCH_W-1:0] mem [DEPTH];
    logic [DATA_W+EPOCH_W-1:0] rd_word_reg;
    logic [EPOCH_W-1:0]        epoch_reg;
    logic [EPOCH_W-1:0]        rd_epoch_reg;

    // cells written before the current epoch read as empty; the epoch is
    // stored with the data and compared against a captured epoch at read time.
    // the owner sweeps the map with zeros after reset and before the counter
    // comes back to an epoch still held in some cell
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {epoch_reg, wr_data};
        end
        rd_word_reg  <= mem[rd_addr];
        rd_epoch_reg <= epoch_reg;
    end

    // epoch counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_W'(1);
        end
        else if (clear)
        begin
            epoch_reg <= epoch_reg + EPOCH_W'(1);
        end
    end

    assign rd_data = (rd_word_reg[DATA_W+EPOCH_W-1:DATA_W] == rd_epoch_reg)
                     ? rd_word_reg[DATA_W-1:0] : '0;

endmodule

`default_nettype wire

/* hw/rtl/grid_chain_reaction_flood.sv */
// top level of the grid chain reaction flood block
// uses gcrf_pkg and gcrf_cell_map
// A load beat places a bomb if it lies inside the grid and the store has room.
// A trigger beat with a loaded start bomb runs a breadth-first walk from it:
// each bomb taken from the queue passes the queue and coordinate access states
// (ST_START, ST_POP, ST_COORD), then every probed grid cell takes a read of the
// single cell map port and a check, four times reach cells per bomb (a single
// check when reach is zero); after the walk the count is offered on the output
// channel and the case is cleared. The cell map is cleared by an epoch mark, so
// no clearing pass is needed, except that every 255 cases (and after reset) the
// block sweeps the map once, one cell a cycle, while accepting no beat.
`default_nettype none

module grid_chain_reaction_flood
    import gcrf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid,
    output logic                  ready,
    input  wire logic             kind,
    input  wire logic [5:0]       pos_x,
    input  wire logic [5:0]       pos_y,
    input  wire logic [7:0]       start_bomb,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [8:0]            exploded_count,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int XW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW   = XW + YW;
    localparam int NCELL = 1 << AW;
    localparam int BW   = (MAX_BOMBS > 1) ? $clog2(MAX_BOMBS) : 1;
    localparam int TW   = $clog2(MAX_BOMBS + 1);
    localparam int DW   = TW;

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_START, ST_POP, ST_COORD, ST_PROBE,
        ST_CHECK, ST_OUT
    } state_t;

    state_t           state_reg;
    logic [6:0]       width_reg, height_reg;
    logic [5:0]       reach_reg;
    logic [TW-1:0]    total_reg;
    logic [TW-1:0]    head_reg, tail_reg, count_reg;
    logic [MAX_BOMBS-1:0] visited_reg;
    logic [XW-1:0]    cx_reg;
    logic [YW-1:0]    cy_reg;
    logic [5:0]       step_reg;
    dir_t             dir_reg;
    logic [8:0]       result_reg;
    logic [AW:0]      sweep_reg;
    logic [7:0]       clears_reg;
    logic             pok_reg;

    logic [AW-1:0]    bomb_xy [MAX_BOMBS];
    logic [BW-1:0]    queue   [MAX_BOMBS];
    logic [AW-1:0]    xy_rd_reg;
    logic [BW-1:0]    q_rd_reg;

    logic             map_we, map_clear;
    logic [AW-1:0]    map_waddr, map_raddr;
    logic [DW-1:0]    map_wdata, map_rdata;

    // effective grid size, clipped to the build limits
    logic [8:0] w_eff, h_eff;
    assign w_eff = (9'(width_reg)  > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : 9'(width_reg);
    assign h_eff = (9'(height_reg) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(height_reg);

    // load acceptance check
    logic load_ok;
    assign load_ok = ({3'b0, pos_x} < w_eff) && ({3'b0, pos_y} < h_eff)
                     && (total_reg < TW'(MAX_BOMBS))
                     && (7'(pos_x) < 7'(MAX_WIDTH)) && (7'(pos_y) < 7'(MAX_HEIGHT));

    assign ready     = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign exploded_count = result_reg;

    // probe target for current direction and step
    logic [8:0] tx, ty;
    logic       t_ok;
    always_comb
    begin
        tx = 9'(cx_reg);
        ty = 9'(cy_reg);
        t_ok = 1'b0;
        unique case (dir_reg)
            DIR_LEFT:
            begin
                tx = 9'(cx_reg) - 9'(step_reg);
                t_ok = 9'(cx_reg) >= 9'(step_reg);
            end
            DIR_RIGHT:
            begin
                tx = 9'(cx_reg) + 9'(step_reg);
                t_ok = tx < w_eff;
            end
            DIR_UP:
            begin
                ty = 9'(cy_reg) - 9'(step_reg);
                t_ok = 9'(cy_reg) >= 9'(step_reg);
            end
            DIR_DOWN:
            begin
                ty = 9'(cy_reg) + 9'(step_reg);
                t_ok = ty < h_eff;
            end
            default: t_ok = 1'b0;
        endcase
    end

    // cell map port control
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = {pos_y[YW-1:0], pos_x[XW-1:0]};
        map_wdata = DW'(total_reg) + DW'(1);
        map_raddr = {ty[YW-1:0], tx[XW-1:0]};
        map_clear = 1'b0;
        if (state_reg == ST_SWEEP)
        begin
            map_we    = 1'b1;
            map_waddr = sweep_reg[AW-1:0];
            map_wdata = '0;
        end
        else if (state_reg == ST_IDLE && valid && kind == KIND_LOAD && load_ok)
        begin
            map_we = 1'b1;
        end
        if (state_reg == ST_OUT && out_ready)
        begin
            map_clear = 1'b1;
        end
    end

    gcrf_cell_map #(.ADDR_W(AW), .DATA_W(DW)) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (map_raddr),
        .clear   (map_clear || state_reg == ST_SWEEP),
        .rd_data (map_rdata)
    );

    // bomb coordinate store and walk queue memories
    logic           q_we;
    logic [BW-1:0]  q_waddr, q_wdata;
    logic [DW-1:0]  hit;
    logic           hit_new;
    assign hit     = map_rdata - DW'(1);
    assign hit_new = pok_reg && (map_rdata != '0) && (hit < DW'(MAX_BOMBS))
                     && !visited_reg[hit[BW-1:0]];
    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = tail_reg[BW-1:0];
        q_wdata = start_bomb[BW-1:0];
        if (state_reg == ST_IDLE && valid && kind == KIND_TRIGGER)
        begin
            // start bomb always sits at the queue front
            q_we    = 1'b1;
            q_waddr = '0;
        end
        else if (state_reg == ST_CHECK && hit_new && tail_reg < TW'(MAX_BOMBS))
        begin
            q_we    = 1'b1;
            q_wdata = hit[BW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && valid && kind == KIND_LOAD && load_ok)
        begin
            bomb_xy[total_reg[BW-1:0]] <= {pos_y[YW-1:0], pos_x[XW-1:0]};
        end
        if (q_we)
        begin
            queue[q_waddr] <= q_wdata;
        end
        q_rd_reg  <= queue[head_reg[BW-1:0]];
        xy_rd_reg <= bomb_xy[q_rd_reg];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SWEEP;
            width_reg   <= 7'd64;
            height_reg  <= 7'd64;
            reach_reg   <= 6'd1;
            total_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            visited_reg <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            step_reg    <= '0;
            dir_reg     <= DIR_LEFT;
            result_reg  <= '0;
            sweep_reg   <= '0;
            clears_reg  <= '0;
            pok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  width_reg  <= cfg_data;
                    REG_GRID_HEIGHT: height_reg <= cfg_data;
                    REG_REACH:       reach_reg  <= cfg_data[5:0];
                    default:         ;
                endcase
            end
            unique case (state_reg)
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + (AW+1)'(1);
                    if (sweep_reg == (AW+1)'(NCELL - 1))
                    begin
                        state_reg <= ST_IDLE;
                        sweep_reg <= '0;
                    end
                end
                ST_IDLE:
                begin
                    if (valid)
                    begin
                        if (kind == KIND_LOAD)
                        begin
                            if (load_ok)
                            begin
                                total_reg <= total_reg + TW'(1);
                            end
                        end
                        else if (TW'(start_bomb) < total_reg)
                        begin
                            visited_reg[start_bomb[BW-1:0]] <= 1'b1;
                            head_reg  <= '0;
                            tail_reg  <= TW'(1);
                            count_reg <= '0;
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            result_reg <= '0;
                            state_reg  <= ST_OUT;
                        end
                    end
                end
                ST_START:
                begin
                    // queue read of head in flight
                    state_reg <= ST_POP;
                end
                ST_POP:
                begin
                    // coordinate read in flight
                    state_reg <= ST_COORD;
                end
                ST_COORD:
                begin
                    cx_reg    <= xy_rd_reg[XW-1:0];
                    cy_reg    <= xy_rd_reg[AW-1:XW];
                    head_reg  <= head_reg + TW'(1);
                    count_reg <= count_reg + TW'(1);
                    step_reg  <= 6'd1;
                    dir_reg   <= DIR_LEFT;
                    pok_reg   <= 1'b0;
                    state_reg <= (reach_reg == 6'd0) ? ST_CHECK : ST_PROBE;
                end
                ST_PROBE:
                begin
                    // issue one cell read; result checked next cycle
                    pok_reg   <= t_ok;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (hit_new)
                    begin
                        visited_reg[hit[BW-1:0]] <= 1'b1;
                        if (tail_reg < TW'(MAX_BOMBS))
                        begin
                            tail_reg <= tail_reg + TW'(1);
                        end
                    end
                    pok_reg <= 1'b0;
                    if (reach_reg != 6'd0 && !(dir_reg == DIR_DOWN && step_reg == reach_reg))
                    begin
                        if (dir_reg == DIR_DOWN)
                        begin
                            dir_reg  <= DIR_LEFT;
                            step_reg <= step_reg + 6'd1;
                        end
                        else
                        begin
                            dir_reg <= dir_t'(dir_reg + 2'd1);
                        end
                        state_reg <= ST_PROBE;
                    end
                    else if (head_reg != tail_reg || (hit_new && tail_reg < TW'(MAX_BOMBS)))
                    begin
                        state_reg <= ST_START;
                    end
                    else
                    begin
                        result_reg <= 9'(count_reg);
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        total_reg   <= '0;
                        visited_reg <= '0;
                        clears_reg  <= clears_reg + 8'd1;
                        state_reg   <= (clears_reg == 8'd254) ? ST_SWEEP : ST_IDLE;
                        if (clears_reg == 8'd254)
                        begin
                            clears_reg <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
